// File: design/linear_probe_hash_table_macros.svh
// assertion macros for the linear probe hash table
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPHT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LPHT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lpht_pkg.sv
// shared constants and types for the linear probe hash table
package lpht_pkg;

  localparam int TableBitsDefault = 8;

  localparam logic [31:0] GoldenMult = 32'h9E37_79B9;

  localparam int KeyW   = 32;
  localparam int ValW   = 32;
  localparam int CountW = 9;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  localparam logic [1:0] FlagEmpty = 2'd0;
  localparam logic [1:0] FlagUsed  = 2'd1;
  localparam logic [1:0] FlagTomb  = 2'd2;

  typedef struct packed {
    logic flag_we;
    logic key_we;
    logic val_we;
  } slot_we_t;

endpackage

// File: design/lpht_slot_mem.sv
// slot storage: flag, key and value memories with one write and one registered read port
module lpht_slot_mem #(
  parameter int TABLE_BITS = lpht_pkg::TableBitsDefault
) (
  input  logic                        clk_i,
  input  lpht_pkg::slot_we_t          we_i,
  input  logic [TABLE_BITS-1:0]       wr_addr_i,
  input  logic [1:0]                  wr_flag_i,
  input  logic [lpht_pkg::KeyW-1:0]   wr_key_i,
  input  logic [lpht_pkg::ValW-1:0]   wr_val_i,
  input  logic [TABLE_BITS-1:0]       rd_addr_i,
  output logic [1:0]                  rd_flag_o,
  output logic [lpht_pkg::KeyW-1:0]   rd_key_o,
  output logic [lpht_pkg::ValW-1:0]   rd_val_o
);

  localparam int SlotCount = 1 << TABLE_BITS;

  logic [1:0]                flag_mem [SlotCount];
  logic [lpht_pkg::KeyW-1:0] key_mem  [SlotCount];
  logic [lpht_pkg::ValW-1:0] val_mem  [SlotCount];

  always_ff @(posedge clk_i) begin
    if (we_i.flag_we) begin
      flag_mem[wr_addr_i] <= wr_flag_i;
    end
    rd_flag_o <= flag_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    rd_key_o <= key_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.val_we) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
    rd_val_o <= val_mem[rd_addr_i];
  end

endmodule

// File: design/linear_probe_hash_table.sv
// Open-addressing key/value table of 2^TABLE_BITS slots with linear probing. One request is
// taken at a time. Insert, lookup and remove pass through a hash step, then probe one slot at
// a time (1 to 2^TABLE_BITS probes), each probe being one read of the slot memories, and then
// an output step. Clear, and the pass that follows reset, sweep all 2^TABLE_BITS slots of the
// flag memory one slot per cycle, during which no request is taken. The request side opens
// again once the result has moved into the output register.
module linear_probe_hash_table #(
  parameter int TABLE_BITS = lpht_pkg::TableBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] key, [63:32] value
  input  logic [63:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] ok, [32:1] read_value, [41:33] occupied_count, [47:42] zero
  output logic [47:0] m_axis_tdata
);

  localparam int CntW = TABLE_BITS + 1;
  localparam logic [CntW-1:0] SlotCnt = {1'b1, {TABLE_BITS{1'b0}}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HASH  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CLR   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q;
  logic       emit_q;

  logic [1:0]                op_q;
  logic [lpht_pkg::KeyW-1:0] key_q;
  logic [lpht_pkg::ValW-1:0] val_q;
  logic [31:0]               prod_q;
  logic [31:0]               prod_d;

  logic [TABLE_BITS-1:0] pos_q;
  logic [TABLE_BITS-1:0] pos_inc;
  logic [TABLE_BITS-1:0] steps_q;
  logic [TABLE_BITS-1:0] free_q, free_d;
  logic                  have_free_q, have_free_d;
  logic [TABLE_BITS-1:0] clr_idx_q;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic                      res_ok_q;
  logic [lpht_pkg::ValW-1:0] res_rd_q;
  logic                      out_valid_q;
  logic [47:0]               out_data_q;
  logic                      out_load;

  logic                  in_acc;
  logic                  last_probe;
  logic [TABLE_BITS-1:0] home;
  logic [TABLE_BITS-1:0] rd_addr;
  logic                  hit;
  logic                  fr_v;
  logic [TABLE_BITS-1:0] fr_p;
  logic                  done;
  logic                  ok_d;
  logic [lpht_pkg::ValW-1:0] rd_d;

  lpht_pkg::slot_we_t        wr_we;
  logic [TABLE_BITS-1:0]     wr_addr;
  logic [1:0]                wr_flag;
  logic [1:0]                rd_flag;
  logic [lpht_pkg::KeyW-1:0] rd_key;
  logic [lpht_pkg::ValW-1:0] rd_val;

  logic [CntW+lpht_pkg::CountW-1:0] cnt_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign prod_d        = s_axis_tdata[31:0] * lpht_pkg::GoldenMult;
  assign home          = prod_q[31 -: TABLE_BITS];
  assign pos_inc       = pos_q + 1'b1;
  assign last_probe    = &steps_q;
  assign rd_addr       = (state_q == ST_HASH) ? home : pos_inc;
  assign hit           = (rd_flag == lpht_pkg::FlagUsed) && (rd_key == key_q);
  assign cnt_ext       = {{lpht_pkg::CountW{1'b0}}, cnt_q};
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  lpht_slot_mem #(
    .TABLE_BITS(TABLE_BITS)
  ) u_slot_mem (
    .clk_i    (clk_i),
    .we_i     (wr_we),
    .wr_addr_i(wr_addr),
    .wr_flag_i(wr_flag),
    .wr_key_i (key_q),
    .wr_val_i (val_q),
    .rd_addr_i(rd_addr),
    .rd_flag_o(rd_flag),
    .rd_key_o (rd_key),
    .rd_val_o (rd_val)
  );

  // probe step decision and clear sweep writes
  always_comb begin
    wr_we       = '0;
    wr_addr     = pos_q;
    wr_flag     = lpht_pkg::FlagUsed;
    done        = 1'b0;
    ok_d        = 1'b0;
    rd_d        = '0;
    cnt_d       = cnt_q;
    fr_v        = have_free_q;
    fr_p        = free_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    if (state_q == ST_CLR) begin
      wr_we.flag_we = 1'b1;
      wr_addr       = clr_idx_q;
      wr_flag       = lpht_pkg::FlagEmpty;
      if (&clr_idx_q) begin
        cnt_d = '0;
      end
    end else if (state_q == ST_PROBE) begin
      case (op_q)
        lpht_pkg::OpInsert: begin
          if (hit) begin
            wr_we.val_we = 1'b1;
            done         = 1'b1;
            ok_d         = 1'b1;
          end else begin
            if ((rd_flag != lpht_pkg::FlagUsed) && !have_free_q) begin
              fr_v = 1'b1;
              fr_p = pos_q;
            end
            have_free_d = fr_v;
            free_d      = fr_p;
            if ((rd_flag == lpht_pkg::FlagEmpty) || last_probe) begin
              done = 1'b1;
              if (fr_v && (cnt_q < SlotCnt)) begin
                wr_we   = '{flag_we: 1'b1, key_we: 1'b1, val_we: 1'b1};
                wr_addr = fr_p;
                ok_d    = 1'b1;
                cnt_d   = cnt_q + 1'b1;
              end
            end
          end
        end
        lpht_pkg::OpLookup, lpht_pkg::OpRemove: begin
          if (hit) begin
            done = 1'b1;
            ok_d = 1'b1;
            if (op_q == lpht_pkg::OpLookup) begin
              rd_d = rd_val;
            end else begin
              wr_we.flag_we = 1'b1;
              wr_flag       = lpht_pkg::FlagTomb;
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          end else if ((rd_flag == lpht_pkg::FlagEmpty) || last_probe) begin
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      val_q  <= s_axis_tdata[63:32];
      prod_q <= prod_d;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      emit_q      <= 1'b0;
      clr_idx_q   <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      steps_q     <= '0;
      free_q      <= '0;
      have_free_q <= 1'b0;
      res_ok_q    <= 1'b0;
      res_rd_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == lpht_pkg::OpClear) begin
              state_q   <= ST_CLR;
              clr_idx_q <= '0;
              emit_q    <= 1'b1;
            end else begin
              state_q <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          pos_q       <= home;
          steps_q     <= '0;
          have_free_q <= 1'b0;
          state_q     <= ST_PROBE;
        end
        ST_PROBE: begin
          if (done) begin
            res_ok_q <= ok_d;
            res_rd_q <= rd_d;
            state_q  <= ST_OUT;
          end else begin
            pos_q       <= pos_inc;
            steps_q     <= steps_q + 1'b1;
            have_free_q <= have_free_d;
            free_q      <= free_d;
          end
        end
        ST_CLR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (&clr_idx_q) begin
            res_ok_q <= 1'b1;
            res_rd_q <= '0;
            emit_q   <= 1'b0;
            state_q  <= emit_q ? ST_OUT : ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {6'b0, cnt_ext[lpht_pkg::CountW-1:0], res_rd_q, res_ok_q};
    end
  end

`include "linear_probe_hash_table_macros.svh"

  `LPHT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= SlotCnt, "occupied count above table size")
  `LPHT_ASSERT_NOW(a_no_idle_write,
    state_q == ST_IDLE || state_q == ST_HASH || state_q == ST_OUT, wr_we == '0,
    "slot memory written outside probe or clear")
  `LPHT_ASSERT_NOW(a_result_from_out, $rose(m_axis_tvalid), $past(state_q) == ST_OUT,
    "result raised outside output step")
  `LPHT_ASSERT_NEXT(a_clear_sweep, in_acc && s_axis_tuser == lpht_pkg::OpClear,
    state_q == ST_CLR && clr_idx_q == '0, "clear request did not start the sweep")

endmodule

// File: tb/tb.sv
// self-checking testbench for the linear probe hash table: directed table, then random phases
`timescale 1ns / 1ps

module tb;

  localparam int TableBits = lpht_pkg::TableBitsDefault;
  localparam int SlotCount = 1 << TableBits;
  localparam int SlotMask  = SlotCount - 1;
  localparam int WordBits  = 32;
  localparam int KeyW      = lpht_pkg::KeyW;
  localparam int ValW      = lpht_pkg::ValW;
  localparam int CountW    = lpht_pkg::CountW;

  typedef struct packed {
    logic              ok;
    logic [ValW-1:0]   rd;
    logic [CountW-1:0] cnt;
  } table_result_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic              typed;
    logic              ok;
    logic [ValW-1:0]   rd;
    logic [CountW-1:0] cnt;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = lpht_pkg::OpLookup;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  linear_probe_hash_table #(.TABLE_BITS(TableBits)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the table
  logic [1:0]      shadow_flag [SlotCount];
  logic [KeyW-1:0] shadow_key  [SlotCount];
  logic [ValW-1:0] shadow_val  [SlotCount];
  int unsigned     shadow_total;

  table_result_t   pending_results [$];
  logic [KeyW-1:0] key_pool [$];
  logic [KeyW-1:0] fill_keys [$];
  dir_row_t        dir_rows [21];

  int fail_count;
  int burst_left;
  int sent_by_op [4];
  int full_rejects;
  int peak_count;
  int results_seen;

  logic [9:0] rx_phase = '0;
  int         rx_stall = 0;

  function automatic int unsigned home_of(logic [KeyW-1:0] k);
    logic [31:0] prod;
    prod = k * lpht_pkg::GoldenMult;
    return (prod >> (WordBits - TableBits)) & SlotMask;
  endfunction

  function automatic int unsigned probe_find(logic [KeyW-1:0] k);
    int unsigned base;
    int unsigned pos;
    base = home_of(k);
    for (int i = 0; i < SlotCount; i++) begin
      pos = (base + i) & SlotMask;
      if (shadow_flag[pos] == lpht_pkg::FlagEmpty) return SlotCount;
      if (shadow_flag[pos] == lpht_pkg::FlagUsed && shadow_key[pos] == k) return pos;
    end
    return SlotCount;
  endfunction

  function automatic logic probe_insert(logic [KeyW-1:0] k, logic [ValW-1:0] v);
    int unsigned base;
    int unsigned pos;
    int unsigned free_pos;
    logic have_free;
    base = home_of(k);
    free_pos = 0;
    have_free = 1'b0;
    for (int i = 0; i < SlotCount; i++) begin
      pos = (base + i) & SlotMask;
      if (shadow_flag[pos] == lpht_pkg::FlagUsed) begin
        if (shadow_key[pos] == k) begin
          shadow_val[pos] = v;
          return 1'b1;
        end
      end else if (shadow_flag[pos] == lpht_pkg::FlagEmpty) begin
        if (!have_free) begin
          free_pos = pos;
          have_free = 1'b1;
        end
        break;
      end else if (!have_free) begin
        free_pos = pos;
        have_free = 1'b1;
      end
    end
    if (!have_free || shadow_total >= SlotCount) return 1'b0;
    shadow_flag[free_pos] = lpht_pkg::FlagUsed;
    shadow_key[free_pos] = k;
    shadow_val[free_pos] = v;
    shadow_total++;
    return 1'b1;
  endfunction

  function automatic void shadow_clear();
    for (int i = 0; i < SlotCount; i++) begin
      shadow_flag[i] = lpht_pkg::FlagEmpty;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    shadow_total = 0;
  endfunction

  function automatic table_result_t predict_table_op(logic [1:0] op, logic [KeyW-1:0] k,
                                                     logic [ValW-1:0] v);
    table_result_t r;
    int unsigned pos;
    r = '0;
    case (op)
      lpht_pkg::OpInsert: begin
        r.ok = probe_insert(k, v);
      end
      lpht_pkg::OpLookup: begin
        pos = probe_find(k);
        if (pos < SlotCount) begin
          r.ok = 1'b1;
          r.rd = shadow_val[pos];
        end
      end
      lpht_pkg::OpRemove: begin
        pos = probe_find(k);
        if (pos < SlotCount) begin
          shadow_flag[pos] = lpht_pkg::FlagTomb;
          if (shadow_total > 0) shadow_total--;
          r.ok = 1'b1;
        end
      end
      default: begin
        shadow_clear();
        r.ok = 1'b1;
      end
    endcase
    r.cnt = shadow_total[CountW-1:0];
    return r;
  endfunction

  task automatic send_request(logic [1:0] op, logic [KeyW-1:0] k, logic [ValW-1:0] v,
                              logic typed = 1'b0, table_result_t typed_res = '0);
    table_result_t r;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    r = predict_table_op(op, k, v);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    sent_by_op[op]++;
    if (op == lpht_pkg::OpInsert && !r.ok) full_rejects++;
    if (shadow_total > peak_count) peak_count = shadow_total;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key(int pool_cap);
    logic [KeyW-1:0] k;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return {KeyW{1'b1}};
    if (r < 6) return '0;
    if (r < 75 && key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = $urandom;
    if (key_pool.size() < pool_cap) key_pool.push_back(k);
    else key_pool[$urandom_range(0, key_pool.size() - 1)] = k;
    return k;
  endfunction

  task automatic random_mix(int n, int pool_cap, int ins_pct, int look_pct, int rem_pct);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 999);
      if (r < ins_pct * 10) op = lpht_pkg::OpInsert;
      else if (r < (ins_pct + look_pct) * 10) op = lpht_pkg::OpLookup;
      else if (r < (ins_pct + look_pct + rem_pct) * 10) op = lpht_pkg::OpRemove;
      else if (r < 997) op = lpht_pkg::OpLookup;
      else op = lpht_pkg::OpClear;
      send_request(op, pick_key(pool_cap), $urandom);
    end
  endtask

  // receiver: open stretches, then random stalls
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase[9:8] == 2'd0) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= $urandom_range(0, 15);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[0] !== exp_r.ok) begin
          $error("ok: expected %0d, got %0d", exp_r.ok, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[32:1] !== exp_r.rd) begin
          $error("read_value: expected %h, got %h", exp_r.rd, m_axis_tdata[32:1]);
          fail_count++;
        end
        if (m_axis_tdata[41:33] !== exp_r.cnt) begin
          $error("occupied_count: expected %0d, got %0d", exp_r.cnt, m_axis_tdata[41:33]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] k;
    table_result_t   left_r;
    shadow_clear();
    fail_count = 0;
    burst_left = 0;
    full_rejects = 0;
    peak_count = 0;
    results_seen = 0;
    foreach (sent_by_op[i]) sent_by_op[i] = 0;

    dir_rows = '{
      '{lpht_pkg::OpLookup, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpRemove, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpInsert, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 9'd1},
      '{lpht_pkg::OpInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 9'd2},
      '{lpht_pkg::OpLookup, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 9'd2},
      '{lpht_pkg::OpLookup, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 9'd2},
      '{lpht_pkg::OpInsert, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0000_0000, 9'd2},
      '{lpht_pkg::OpLookup, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5, 9'd2},
      '{lpht_pkg::OpRemove, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 9'd1},
      '{lpht_pkg::OpRemove, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 9'd1},
      '{lpht_pkg::OpLookup, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 9'd1},
      '{lpht_pkg::OpInsert, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, 1'b1, 32'h0000_0000, 9'd2},
      '{lpht_pkg::OpInsert, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpInsert, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpLookup, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpRemove, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpLookup, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpClear,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpLookup, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpClear,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 9'd0},
      '{lpht_pkg::OpInsert, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 9'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].value, dir_rows[i].typed,
                   '{dir_rows[i].ok, dir_rows[i].rd, dir_rows[i].cnt});
    end

    // light load, small key set
    random_mix(550, 48, 35, 35, 25);
    wait_drained();

    // fill to capacity, then overflow, churn and tombstone everything
    send_request(lpht_pkg::OpClear, $urandom, $urandom);
    while (shadow_total < SlotCount) begin
      k = $urandom;
      fill_keys.push_back(k);
      send_request(lpht_pkg::OpInsert, k, $urandom);
    end
    repeat (3) send_request(lpht_pkg::OpInsert, $urandom, $urandom);
    send_request(lpht_pkg::OpInsert, fill_keys[$urandom_range(0, fill_keys.size() - 1)],
                 $urandom);
    repeat (3) send_request(lpht_pkg::OpLookup, $urandom, $urandom);
    repeat (10) send_request(lpht_pkg::OpLookup,
                             fill_keys[$urandom_range(0, fill_keys.size() - 1)], 0);
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_request(lpht_pkg::OpRemove, fill_keys[$urandom_range(0, fill_keys.size() - 1)],
                   $urandom);
      k = $urandom;
      fill_keys.push_back(k);
      send_request(lpht_pkg::OpInsert, k, $urandom);
    end
    foreach (fill_keys[i]) send_request(lpht_pkg::OpRemove, fill_keys[i], $urandom);
    repeat (5) send_request(lpht_pkg::OpLookup, $urandom, $urandom);
    for (int i = 0; i < 10; i++) begin
      k = $urandom;
      send_request(lpht_pkg::OpInsert, k, $urandom);
      send_request(lpht_pkg::OpLookup, k, 0);
    end

    // heavier load, wide key set
    send_request(lpht_pkg::OpClear, 0, 0);
    key_pool.delete();
    random_mix(520, 300, 55, 25, 15);

    wait_drained();
    repeat (2 * SlotCount + 8) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      left_r = pending_results.pop_front();
      $error("request never answered: ok %0d", left_r.ok);
      fail_count++;
    end

    $display("ran %0d inserts, %0d lookups, %0d removes, %0d clears, %0d results checked",
             sent_by_op[lpht_pkg::OpInsert], sent_by_op[lpht_pkg::OpLookup],
             sent_by_op[lpht_pkg::OpRemove], sent_by_op[lpht_pkg::OpClear], results_seen);
    $display("peak occupancy %0d of %0d slots, %0d inserts rejected on a full table",
             peak_count, SlotCount, full_rejects);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
